// File: design/median_of_non_null_set_unit_macros.svh
// Assertion helpers for the median unit. Each expects clk and rst_n in scope.
`ifndef MEDIAN_OF_NON_NULL_SET_UNIT_MACROS_SVH
`define MEDIAN_OF_NON_NULL_SET_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MONNS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("median unit: same-cycle check failed");
// Next-cycle implication
`define MONNS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("median unit: next-cycle check failed");
`else
`define MONNS_ASSERT_IMPL(name, ante, cons)
`define MONNS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: design/monns_pkg.sv
`default_nettype none

package monns_pkg;

  // Store geometry and value format
  localparam int MAX_VALUES = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);
  localparam int OUT_BITS   = VALUE_BITS + 1;

  // Input item
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample;
    logic                         sample_is_null;
    logic                         end_of_set;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [OUT_BITS-1:0] median_doubled;
    logic                       result_null;
    logic                       capacity_overflow;
  } out_item_t;

  // Control states
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast from the controller to the row of cells
  typedef struct packed {
    cell_op_t                     op;
    logic signed [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]             cnt;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/monns_cell.sv
`default_nettype none

module monns_cell
  import monns_pkg::*;
(
  input  wire logic                         clk,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic [IDX_W-1:0]             idx,
  input  wire logic signed [VALUE_BITS-1:0] left_val,
  input  wire logic                         left_less,
  input  wire logic signed [VALUE_BITS-1:0] right_val,
  output logic signed [VALUE_BITS-1:0]      val,
  output logic                              less
);

  logic signed [VALUE_BITS-1:0] val_r;
  logic signed [VALUE_BITS-1:0] val_nxt;
  logic                         occupied;

  // An empty slot behaves like +infinity: the new value goes below it
  assign occupied = ({1'b0, idx} < ctrl.cnt);
  assign less     = !occupied || (ctrl.value < val_r);
  assign val      = val_r;

  // Insert: first slot above the new value takes it, the rest move up.
  // Shift: move one slot toward cell 0 during readout.
  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (less) begin
          val_nxt = left_less ? left_val : ctrl.value;
        end
      end
      CELL_SHIFT: val_nxt = right_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// File: design/median_of_non_null_set_unit.sv
// Median of a set of signed fixed-point values (8 fraction bits).
// Input channel in_valid/in_ready/in_data carries one element per transfer with
// a null mark and an end-of-set mark; null elements are skipped. Non-null values
// enter a row of MAX_VALUES sorting cells, one element per cycle, kept in
// ascending order. A value arriving with the row full is dropped and flagged.
// On the end-of-set transfer the row is read out by shifting toward cell 0
// until the value at the lower middle index lo = (kept_count-1)/2 reaches
// cell 0; the result then goes to the output register. New input is
// not taken during readout. Throughput: one element per cycle within a set,
// plus the readout at each set end.
// Output channel out_valid/out_ready/out_data gives twice the median (sum of the
// two middle values for an even count), a null flag for an empty set and an
// overflow flag. The result sits in an output register; input elements keep
// flowing while it waits. If the receiver stalls at the next set end, the
// readout holds until the register is free.
// Reset (rst_n low, synchronous) empties the set and drops any pending result.
`default_nettype none
`include "median_of_non_null_set_unit_macros.svh"

module median_of_non_null_set_unit
  import monns_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  drop_r, drop_nxt;
  logic [IDX_W-1:0]      sh_r, sh_nxt;
  logic [IDX_W-1:0]      lo_r, lo_nxt;
  logic                  even_r, even_nxt;
  logic                  null_r, null_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_xfer;
  logic                  full;
  logic                  do_insert;
  logic [CNT_W-1:0]      cnt_after;
  logic [CNT_W-1:0]      half;
  logic                  at_lo;
  logic                  out_free;
  logic                  finish;
  cell_ctrl_t            ctrl;

  logic signed [VALUE_BITS-1:0] cell_val  [MAX_VALUES];
  logic                         cell_less [MAX_VALUES];
  logic signed [OUT_BITS-1:0]   mid_a;
  logic signed [OUT_BITS-1:0]   mid_b;

  // Handshake and insertion decode
  assign in_xfer   = in_valid && in_ready;
  assign full      = (cnt_r == CNT_W'(MAX_VALUES));
  assign do_insert = in_xfer && !in_data.sample_is_null && !full;
  assign cnt_after = cnt_r + CNT_W'(do_insert);
  assign half      = cnt_after >> 1;
  assign at_lo     = (sh_r == lo_r);
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == ST_DRAIN) && at_lo && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_data.end_of_set) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (at_lo && out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs of the state machine: handshake and cell command
  always_comb begin
    in_ready   = 1'b0;
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_data.sample;
    ctrl.cnt   = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (do_insert) begin
          ctrl.op = CELL_INSERT;
        end
      end
      ST_DRAIN: begin
        if (!at_lo) begin
          ctrl.op = CELL_SHIFT;
        end
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  // Middle values sit in cells 0 and 1 once lo shifts are done
  assign mid_a = OUT_BITS'(cell_val[0]);
  assign mid_b = even_r ? OUT_BITS'(cell_val[1]) : OUT_BITS'(cell_val[0]);

  // Set bookkeeping and result register
  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sh_nxt        = sh_r;
    lo_nxt        = lo_r;
    even_nxt      = even_r;
    null_nxt      = null_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (in_xfer) begin
      if (in_data.end_of_set) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
        sh_nxt   = '0;
        null_nxt = (cnt_after == '0);
        even_nxt = !cnt_after[0];
        ovf_nxt  = drop_r || (!in_data.sample_is_null && full);
        if (cnt_after == '0) begin
          lo_nxt = '0;
        end else if (!cnt_after[0]) begin
          lo_nxt = IDX_W'(half - CNT_W'(1));
        end else begin
          lo_nxt = IDX_W'(half);
        end
      end else begin
        cnt_nxt = cnt_after;
        if (!in_data.sample_is_null && full) begin
          drop_nxt = 1'b1;
        end
      end
    end

    if ((state_r == ST_DRAIN) && !at_lo) begin
      sh_nxt = sh_r + IDX_W'(1);
    end

    if (finish) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.median_doubled    = null_r ? '0 : (mid_a + mid_b);
      out_data_nxt.result_null       = null_r;
      out_data_nxt.capacity_overflow = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      sh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      sh_r        <= sh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    even_r     <= even_nxt;
    null_r     <= null_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Row of sorting cells
  for (genvar gi = 0; gi < MAX_VALUES; gi++) begin : g_cell
    logic signed [VALUE_BITS-1:0] lv;
    logic signed [VALUE_BITS-1:0] rv;
    logic                         ll;

    if (gi == 0) begin : g_first
      assign lv = '0;
      assign ll = 1'b0;
    end else begin : g_inner
      assign lv = cell_val[gi-1];
      assign ll = cell_less[gi-1];
    end

    if (gi == MAX_VALUES - 1) begin : g_last
      assign rv = cell_val[gi];
    end else begin : g_next
      assign rv = cell_val[gi+1];
    end

    monns_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (IDX_W'(gi)),
      .left_val  (lv),
      .left_less (ll),
      .right_val (rv),
      .val       (cell_val[gi]),
      .less      (cell_less[gi])
    );
  end

  // Checks
  `MONNS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_VALUES))
  `MONNS_ASSERT_NEXT(a_end_drains, in_xfer && in_data.end_of_set, state_r == ST_DRAIN && cnt_r == '0)
  `MONNS_ASSERT_NEXT(a_insert_counts, do_insert && !in_data.end_of_set, cnt_r == $past(cnt_r) + CNT_W'(1))
  `MONNS_ASSERT_IMPL(a_null_zero, out_valid && out_data.result_null, out_data.median_doubled == '0)

endmodule

`default_nettype wire

// File: bench/median_of_non_null_set_unit_tb.sv
module median_of_non_null_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import monns_pkg::*;

  typedef logic signed [VALUE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX     = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
  // Output hold-off long enough to fill the output register and stall a readout
  localparam int      LONG_STALL     = 600;
  // Leave time for the longest readout, with margin after the last result
  localparam int      DRAIN_CYCLES   = MAX_VALUES + 16;
  localparam int      WATCHDOG_LIMIT = 6000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predictor state: kept values in ascending order, plus the dropped mark
  sample_t   kept_sorted[$];
  bit        overflowed;
  out_item_t pending_medians[$];
  sample_t   recent_sample;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_requests;
  int stall_served;
  int hold_left;
  int idle_cycles;
  int failures;
  int elements_sent;
  int sets_closed;
  int empty_sets;
  int overflow_sets;
  int results_checked;

  median_of_non_null_set_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Twice the median of the kept values, then clear for the next set
  function automatic out_item_t close_set();
    out_item_t                  r;
    int                         half;
    logic signed [OUT_BITS-1:0] lo_v;
    logic signed [OUT_BITS-1:0] hi_v;
    r = '0;
    if (kept_sorted.size() == 0) begin
      r.result_null = 1'b1;
      empty_sets++;
    end else begin
      half = kept_sorted.size() / 2;
      hi_v = kept_sorted[half];
      lo_v = (kept_sorted.size() % 2) ? kept_sorted[half] : kept_sorted[half-1];
      r.median_doubled = lo_v + hi_v;
    end
    r.capacity_overflow = overflowed;
    if (overflowed) overflow_sets++;
    sets_closed++;
    kept_sorted.delete();
    overflowed = 1'b0;
    return r;
  endfunction

  // Insertion into the sorted store; a full store drops the value
  function automatic void absorb_sample(input in_item_t it);
    sample_t v;
    int      pos;
    v = it.sample;
    if (!it.sample_is_null) begin
      if (kept_sorted.size() >= MAX_VALUES) begin
        overflowed = 1'b1;
      end else begin
        pos = 0;
        while (pos < kept_sorted.size() && kept_sorted[pos] <= v) pos++;
        kept_sorted.insert(pos, v);
      end
    end
    if (it.end_of_set) pending_medians.push_back(close_set());
  endfunction

  function automatic in_item_t make_item(input sample_t value, input logic is_null,
                                         input logic is_last);
    in_item_t it;
    it.sample         = value;
    it.sample_is_null = is_null;
    it.end_of_set     = is_last;
    return it;
  endfunction

  // Mix of full-range, small, near-extreme and repeated values
  function automatic sample_t random_sample();
    sample_t v;
    case ($urandom_range(5))
      0: v = sample_t'($urandom_range(1023)) - sample_t'(512);
      1: v = $urandom_range(1) ? SAMPLE_MAX - sample_t'($urandom_range(3))
                               : SAMPLE_MIN + sample_t'($urandom_range(3));
      2: v = recent_sample;
      default: v = sample_t'({$urandom, $urandom});
    endcase
    recent_sample = v;
    return v;
  endfunction

  // One transfer on the input channel, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    elements_sent++;
    absorb_sample(it);
  endtask

  // Non-null values, the last one closing the set
  task automatic send_values(input sample_t vals[$]);
    for (int i = 0; i < vals.size(); i++)
      send_item(make_item(vals[i], 1'b0, i == vals.size() - 1));
  endtask

  // Sender pause until every outstanding median has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Single values and pairs at the ends of the range
  task automatic test_value_extremes();
    sample_t vals[$];
    vals = {SAMPLE_MAX};             send_values(vals);
    vals = {SAMPLE_MIN};             send_values(vals);
    vals = {SAMPLE_MAX, SAMPLE_MAX}; send_values(vals);
    vals = {SAMPLE_MIN, SAMPLE_MIN}; send_values(vals);
    vals = {SAMPLE_MAX, SAMPLE_MIN}; send_values(vals);
    vals = {sample_t'(0)};           send_values(vals);
    wait_for_results();
  endtask

  // Unsorted arrival, odd and even counts, fractional halves
  task automatic test_order_and_parity();
    sample_t vals[$];
    vals = {sample_t'(3), sample_t'(1), sample_t'(2)};                  send_values(vals);
    vals = {sample_t'(4), -sample_t'(4), sample_t'(1), sample_t'(7)};   send_values(vals);
    vals = {sample_t'(384), -sample_t'(1), sample_t'(1)};               send_values(vals);
    vals = {sample_t'(1), sample_t'(2)};                                send_values(vals);
    wait_for_results();
  endtask

  // Null elements inside a set, as the last element, and an all-null set
  task automatic test_null_elements();
    send_item(make_item(SAMPLE_MAX, 1'b1, 1'b0));
    send_item(make_item(sample_t'(5), 1'b0, 1'b0));
    send_item(make_item(SAMPLE_MIN, 1'b1, 1'b0));
    send_item(make_item(sample_t'(9), 1'b0, 1'b0));
    send_item(make_item(-sample_t'(1), 1'b1, 1'b1));
    send_item(make_item(sample_t'(77), 1'b1, 1'b1));
    send_item(make_item(sample_t'(3), 1'b1, 1'b0));
    send_item(make_item(sample_t'(3), 1'b1, 1'b1));
    send_item(make_item(-sample_t'(20), 1'b0, 1'b0));
    send_item(make_item(sample_t'(0), 1'b1, 1'b1));
    wait_for_results();
  endtask

  // Store overrun with a dropped last element, then a store filled exactly
  task automatic test_store_overflow();
    for (int i = 0; i < MAX_VALUES + 3; i++)
      send_item(make_item(random_sample(), 1'b0, i == MAX_VALUES + 2));
    for (int i = 0; i < MAX_VALUES; i++)
      send_item(make_item(random_sample(), 1'b0, 1'b0));
    send_item(make_item(random_sample(), 1'b1, 1'b1));
    wait_for_results();
  endtask

  // Well-formed sets of random size, content and null density
  task automatic test_random_sets(input int target);
    int first;
    int n;
    int r;
    int null_pct;
    first = elements_sent;
    while (elements_sent - first < target) begin
      r = $urandom_range(99);
      if (r < 65)      n = $urandom_range(1, 6);
      else if (r < 97) n = $urandom_range(7, 24);
      else             n = $urandom_range(MAX_VALUES - 2, MAX_VALUES + 3);
      case ($urandom_range(9))
        0:       null_pct = 100;
        1, 2:    null_pct = 50;
        3, 4, 5: null_pct = 15;
        default: null_pct = 0;
      endcase
      for (int i = 0; i < n; i++)
        send_item(make_item(random_sample(), $urandom_range(99) < null_pct, i == n - 1));
    end
    wait_for_results();
  endtask

  // Long output hold-off while sets keep arriving: the input must back up
  task automatic test_output_backpressure();
    int n;
    stall_requests <= stall_requests + 1;
    for (int s = 0; s < 8; s++) begin
      n = $urandom_range(3, 6);
      for (int i = 0; i < n; i++)
        send_item(make_item(random_sample(), $urandom_range(9) == 0, i == n - 1));
    end
    wait_for_results();
  endtask

  // Receiver: random ready, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (stall_requests != stall_served) begin
      stall_served = stall_requests;
      hold_left    = LONG_STALL;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result check against the oldest expected median
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result: median_doubled=%0d result_null=%0b capacity_overflow=%0b",
               out_data.median_doubled, out_data.result_null, out_data.capacity_overflow);
        failures++;
      end else begin
        want = pending_medians.pop_front();
        results_checked++;
        if (out_data.median_doubled !== want.median_doubled) begin
          $error("median_doubled: expected %0d, got %0d",
                 want.median_doubled, out_data.median_doubled);
          failures++;
        end
        if (out_data.result_null !== want.result_null) begin
          $error("result_null: expected %0b, got %0b", want.result_null, out_data.result_null);
          failures++;
        end
        if (out_data.capacity_overflow !== want.capacity_overflow) begin
          $error("capacity_overflow: expected %0b, got %0b",
                 want.capacity_overflow, out_data.capacity_overflow);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_medians.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    out_ready      <= 1'b0;
    stall_requests <= 0;
    stall_served   = 0;
    hold_left      = 0;
    idle_cycles    = 0;
    failures       = 0;
    overflowed     = 1'b0;
    recent_sample  = '0;
    set_idling(23, 83);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_value_extremes();
    test_order_and_parity();
    test_null_elements();
    test_store_overflow();
    test_random_sets(150);
    set_idling(83, 23);
    test_random_sets(150);
    set_idling(0, 0);
    test_random_sets(150);
    test_output_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d elements in %0d sets (%0d empty, %0d overrun), %0d results checked",
             elements_sent, sets_closed, empty_sets, overflow_sets, results_checked);
    $display("with both sides idling, full-store drops and a long output hold-off");
    if (failures == 0 && pending_medians.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: median_of_non_null_set_unit.f
+incdir+design
design/monns_pkg.sv
design/monns_cell.sv
design/median_of_non_null_set_unit.sv
bench/median_of_non_null_set_unit_tb.sv
